// ----- src/adaptive_background_subtract_assert.svh -----
// Assertion macros used by the checker file abs_check.sv.
`ifndef ADAPTIVE_BACKGROUND_SUBTRACT_ASSERT_SVH
`define ADAPTIVE_BACKGROUND_SUBTRACT_ASSERT_SVH

// Property on an explicit clock and active-low reset
`define ABS_ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("abs_check: property violated");

// Property on the usual clk_i / rst_ni pair
`define ABS_ASSERT(lbl, prop) `ABS_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

// ----- src/abs_pkg.sv -----
`default_nettype none

package abs_pkg;

  // Default sizes
  localparam int unsigned PIXEL_COUNT_DEF   = 524288;
  localparam int unsigned FRACTION_BITS_DEF = 16;

  // Field widths
  localparam int unsigned COLOR_W = 8;
  localparam int unsigned INDEX_W = 19;
  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned THR_W   = 8;
  localparam int unsigned RATE_W  = 17;

  // Blend weight scale (1.0 = 65536) and its rounding
  localparam int unsigned RATE_SHIFT = 16;
  localparam logic [RATE_W-1:0] RATE_ONE  = RATE_W'(65536);
  localparam logic [RATE_W-1:0] RATE_HALF = RATE_W'(32768);

  // Register reset values
  localparam logic [THR_W-1:0]  THR_RESET       = THR_W'(10);
  localparam logic [RATE_W-1:0] RATE_RESET      = RATE_W'(197);
  localparam logic [RATE_W-1:0] RATE_KEEP_RESET = RATE_ONE - RATE_RESET;

  // Luma weights, 14 fraction bits
  localparam int unsigned LUMA_W     = 22;
  localparam int unsigned LUMA_SHIFT = 14;
  localparam logic [LUMA_W-1:0] LUMA_B     = LUMA_W'(1868);
  localparam logic [LUMA_W-1:0] LUMA_G     = LUMA_W'(9617);
  localparam logic [LUMA_W-1:0] LUMA_R     = LUMA_W'(4899);
  localparam logic [LUMA_W-1:0] LUMA_ROUND = LUMA_W'(8192);

  // Configuration port
  localparam int unsigned CFG_INDEX_W = 4;
  localparam int unsigned CFG_DATA_W  = 17;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DIFF_THRESHOLD = 4'd0,
    REG_UPDATE_RATE    = 4'd1
  } cfg_reg_e;

  // Result queue depth, also the number of pixels in flight
  localparam int unsigned RESULT_DEPTH = 8;

  typedef struct packed {
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
    logic [INDEX_W-1:0] pixel_index;
    logic               frame_end;
  } pixel_t;

  typedef struct packed {
    logic               foreground;
    logic [LEVEL_W-1:0] background_level;
    logic [LEVEL_W-1:0] gray_level;
  } result_t;

  // Gray value with rounding
  function automatic logic [LEVEL_W-1:0] luma(input logic [COLOR_W-1:0] b,
                                             input logic [COLOR_W-1:0] g,
                                             input logic [COLOR_W-1:0] r);
    logic [LUMA_W-1:0] acc;
    acc = LUMA_B * LUMA_W'(b) + LUMA_G * LUMA_W'(g) + LUMA_R * LUMA_W'(r) + LUMA_ROUND;
    return acc[LUMA_SHIFT +: LEVEL_W];
  endfunction

endpackage

`default_nettype wire

// ----- src/abs_interfaces.sv -----
`default_nettype none

// Pixel channel
interface abs_pixel_if import abs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] blue;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] red;
  logic [INDEX_W-1:0] pixel_index;
  logic               frame_end;

  modport source (output valid, blue, green, red, pixel_index, frame_end, input ready);
  modport sink   (input valid, blue, green, red, pixel_index, frame_end, output ready);
endinterface

// Result channel
interface abs_result_if import abs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               foreground;
  logic [LEVEL_W-1:0] background_level;
  logic [LEVEL_W-1:0] gray_level;

  modport source (output valid, foreground, background_level, gray_level, input ready);
  modport sink   (input valid, foreground, background_level, gray_level, output ready);
endinterface

// Register write channel
interface abs_cfg_if import abs_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- src/abs_ram.sv -----
`default_nettype none

// Simple dual-port RAM, one write and one registered read per cycle
module abs_ram import abs_pkg::*; #(
  parameter int unsigned WIDTH = LEVEL_W + FRACTION_BITS_DEF,
  parameter int unsigned DEPTH = PIXEL_COUNT_DEF,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- src/abs_update.sv -----
`default_nettype none

// Read-modify-write pipeline on the background store.
// s1: gray registered, store read issued, blend term gray*rate formed
// s2: read data (forwarded from the last write on a match), test and blend, write back
// s3: round the new background to a level and push the result
module abs_update import abs_pkg::*; #(
  parameter int unsigned PIXEL_COUNT   = PIXEL_COUNT_DEF,
  parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF,
  localparam int unsigned AW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1,
  localparam int unsigned BW = LEVEL_W + FRACTION_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  pixel_t            pix_i,
  input  logic [THR_W-1:0]  thr_i,
  input  logic [RATE_W-1:0] rate_i,
  input  logic [RATE_W-1:0] keep_i,
  output logic [AW-1:0]     rd_addr_o,
  input  logic [BW-1:0]     rd_data_i,
  output logic              wr_en_o,
  output logic [AW-1:0]     wr_addr_o,
  output logic [BW-1:0]     wr_data_o,
  output logic              push_o,
  output result_t           res_o
);

  localparam int unsigned PW = LEVEL_W + RATE_W + FRACTION_BITS;
  localparam logic [BW:0] LEVEL_HALF = (BW+1)'(1) << (FRACTION_BITS - 1);

  // Priming flag, set by the end of the first frame
  logic primed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q <= 1'b0;
    end else if (take_i && pix_i.frame_end) begin
      primed_q <= 1'b1;
    end
  end

  // Stage 1
  logic                 s1_valid_q;
  logic [LEVEL_W-1:0]   s1_gray_q;
  logic [AW-1:0]        s1_addr_q;
  logic                 s1_inr_q;
  logic                 s1_primed_q;
  logic [LEVEL_W+RATE_W-1:0] s1_prod;
  logic [PW-1:0]        s1_term;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= take_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      s1_gray_q   <= luma(pix_i.blue, pix_i.green, pix_i.red);
      s1_addr_q   <= AW'(pix_i.pixel_index);
      s1_inr_q    <= 32'(pix_i.pixel_index) < PIXEL_COUNT;
      s1_primed_q <= primed_q;
    end
  end

  assign rd_addr_o = s1_addr_q;
  assign s1_prod   = s1_gray_q * rate_i;
  assign s1_term   = (PW'(s1_prod) << FRACTION_BITS) + PW'(RATE_HALF);

  // Stage 2
  logic               s2_valid_q;
  logic [LEVEL_W-1:0] s2_gray_q;
  logic [AW-1:0]      s2_addr_q;
  logic               s2_inr_q;
  logic               s2_primed_q;
  logic [PW-1:0]      s2_term_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_gray_q   <= s1_gray_q;
    s2_addr_q   <= s1_addr_q;
    s2_inr_q    <= s1_inr_q;
    s2_primed_q <= s1_primed_q;
    s2_term_q   <= s1_term;
  end

  // Last write, covers the read that saw the store just before it
  logic          fwd_valid_q;
  logic [AW-1:0] fwd_addr_q;
  logic [BW-1:0] fwd_data_q;

  logic [BW-1:0] s2_bg;
  logic [BW-1:0] s2_gfix;
  logic [BW-1:0] s2_thr_fix;
  logic [BW-1:0] s2_diff;
  logic          s2_over;
  logic [PW-1:0] s2_blend;
  logic [BW-1:0] s2_new_bg;
  logic          s2_update;

  assign s2_bg      = (fwd_valid_q && (fwd_addr_q == s2_addr_q)) ? fwd_data_q : rd_data_i;
  assign s2_gfix    = {s2_gray_q, {FRACTION_BITS{1'b0}}};
  assign s2_thr_fix = {thr_i, {FRACTION_BITS{1'b0}}};
  assign s2_diff    = (s2_gfix > s2_bg) ? (s2_gfix - s2_bg) : (s2_bg - s2_gfix);
  assign s2_over    = s2_diff > s2_thr_fix;
  assign s2_blend   = s2_bg * keep_i + s2_term_q;
  assign s2_new_bg  = s2_blend[RATE_SHIFT +: BW];
  assign s2_update  = s2_inr_q && s2_primed_q;

  // Write back: blended value once primed, plain gray while loading
  assign wr_en_o   = s2_valid_q && s2_inr_q;
  assign wr_addr_o = s2_addr_q;
  assign wr_data_o = s2_primed_q ? s2_new_bg : s2_gfix;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else if (wr_en_o) begin
      fwd_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_o) begin
      fwd_addr_q <= wr_addr_o;
      fwd_data_q <= wr_data_o;
    end
  end

  // Stage 3
  logic               s3_valid_q;
  logic               s3_fg_q;
  logic               s3_update_q;
  logic [BW-1:0]      s3_bg_q;
  logic [LEVEL_W-1:0] s3_gray_q;
  logic [BW:0]        s3_round;
  logic [LEVEL_W:0]   s3_level_wide;
  logic [LEVEL_W-1:0] s3_level;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_fg_q     <= s2_update && s2_over;
    s3_update_q <= s2_update;
    s3_bg_q     <= s2_new_bg;
    s3_gray_q   <= s2_gray_q;
  end

  // Round half up, saturate to the level range
  assign s3_round      = {1'b0, s3_bg_q} + LEVEL_HALF;
  assign s3_level_wide = s3_round[BW:FRACTION_BITS];
  assign s3_level      = s3_level_wide[LEVEL_W] ? {LEVEL_W{1'b1}}
                                                : s3_level_wide[LEVEL_W-1:0];

  assign push_o                 = s3_valid_q;
  assign res_o.foreground       = s3_fg_q;
  assign res_o.background_level = s3_update_q ? s3_level : s3_gray_q;
  assign res_o.gray_level       = s3_gray_q;

endmodule

`default_nettype wire

// ----- src/abs_fifo.sv -----
`default_nettype none

// Result queue between the pipeline and the output channel
module abs_fifo import abs_pkg::*; #(
  parameter int unsigned DEPTH = RESULT_DEPTH,
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t push_data_i,
  input  logic    pop_i,
  output logic    valid_o,
  output result_t data_o
);

  result_t          mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + CNT_W'(push_i) - CNT_W'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_ptr_q];

endmodule

`default_nettype wire

// ----- src/adaptive_background_subtract.sv -----
// Channel  | Dir | Payload                                         | Transfer
// pix_i    | in  | blue, green, red, pixel_index, frame_end        | valid & ready
// res_o    | out | foreground, background_level, gray_level        | valid & ready
// cfg_i    | in  | index (0 diff_threshold, 1 update_rate), data   | valid & ready
//
// One pixel per cycle sustained while res_o takes results; a result is offered after
// s1, s2, s3 and the queue. The rate is set by the read-modify-write loop on the store:
// registered read, blend and write-back in the next cycle, last write forwarded.
// Reset clears the pipeline, result queue and priming flag; the store needs no clearing.
// Up to 8 pixels are in flight; pix_i.ready drops once 8 results are owed to res_o.
// cfg_i is always ready.
`default_nettype none

module adaptive_background_subtract import abs_pkg::*; #(
  parameter int unsigned PIXEL_COUNT   = PIXEL_COUNT_DEF,
  parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  abs_pixel_if.sink    pix_i,
  abs_result_if.source res_o,
  abs_cfg_if.sink      cfg_i
);

  localparam int unsigned AW    = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
  localparam int unsigned BW    = LEVEL_W + FRACTION_BITS;
  localparam int unsigned OWE_W = $clog2(RESULT_DEPTH + 1);

  // Configuration registers, rate kept saturated with its complement
  logic [THR_W-1:0]  thr_q;
  logic [RATE_W-1:0] rate_q;
  logic [RATE_W-1:0] keep_q;
  logic [RATE_W-1:0] rate_sat;

  assign cfg_i.ready = 1'b1;
  assign rate_sat    = (cfg_i.data > RATE_ONE) ? RATE_ONE : cfg_i.data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= THR_RESET;
      rate_q <= RATE_RESET;
      keep_q <= RATE_KEEP_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_DIFF_THRESHOLD: begin
          thr_q <= cfg_i.data[THR_W-1:0];
        end
        REG_UPDATE_RATE: begin
          rate_q <= rate_sat;
          keep_q <= RATE_ONE - rate_sat;
        end
        default: begin
        end
      endcase
    end
  end

  // Results owed to the output side bound what may be taken in
  logic [OWE_W-1:0] owe_q;
  logic             take;
  logic             give;

  assign pix_i.ready = owe_q < OWE_W'(RESULT_DEPTH);
  assign take        = pix_i.valid && pix_i.ready;
  assign give        = res_o.valid && res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owe_q <= '0;
    end else begin
      owe_q <= owe_q + OWE_W'(take) - OWE_W'(give);
    end
  end

  pixel_t pix;

  assign pix.blue        = pix_i.blue;
  assign pix.green       = pix_i.green;
  assign pix.red         = pix_i.red;
  assign pix.pixel_index = pix_i.pixel_index;
  assign pix.frame_end   = pix_i.frame_end;

  // Background store
  logic [AW-1:0] rd_addr;
  logic [BW-1:0] rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [BW-1:0] wr_data;

  abs_ram #(
    .WIDTH (BW),
    .DEPTH (PIXEL_COUNT)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Update pipeline
  logic    push;
  result_t push_data;

  abs_update #(
    .PIXEL_COUNT   (PIXEL_COUNT),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_update (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (take),
    .pix_i     (pix),
    .thr_i     (thr_q),
    .rate_i    (rate_q),
    .keep_i    (keep_q),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data),
    .push_o    (push),
    .res_o     (push_data)
  );

  // Result queue
  result_t head;

  abs_fifo #(
    .DEPTH (RESULT_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (give),
    .valid_o     (res_o.valid),
    .data_o      (head)
  );

  assign res_o.foreground       = head.foreground;
  assign res_o.background_level = head.background_level;
  assign res_o.gray_level       = head.gray_level;

endmodule

`default_nettype wire

// ----- src/abs_check.sv -----
`default_nettype none

`include "adaptive_background_subtract_assert.svh"

// Port-level checks on the top level
module abs_check import abs_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               pix_valid_i,
  input wire logic               pix_ready_i,
  input wire logic               res_valid_i,
  input wire logic               res_ready_i,
  input wire logic               res_foreground_i,
  input wire logic [LEVEL_W-1:0] res_background_level_i,
  input wire logic [LEVEL_W-1:0] res_gray_level_i
);

  // Input back-pressure only while results are waiting
  `ABS_ASSERT(a_stall_needs_backlog, !pix_ready_i |-> res_valid_i)

  // A result appearing on an empty output follows a pixel transfer through s1, s2, s3 and the queue
  `ABS_ASSERT(a_result_latency, $rose(res_valid_i) |-> $past(pix_valid_i && pix_ready_i, 4))

  // Offered result stays until its transfer
  `ABS_ASSERT(a_res_valid_holds, res_valid_i && !res_ready_i |=> res_valid_i)

  // Stalled result payload holds
  `ABS_ASSERT(a_res_payload_holds, res_valid_i && !res_ready_i |=> $stable(res_foreground_i) && $stable(res_background_level_i) && $stable(res_gray_level_i))

endmodule

bind adaptive_background_subtract abs_check u_abs_check (
  .clk_i                  (clk_i),
  .rst_ni                 (rst_ni),
  .pix_valid_i            (pix_i.valid),
  .pix_ready_i            (pix_i.ready),
  .res_valid_i            (res_o.valid),
  .res_ready_i            (res_o.ready),
  .res_foreground_i       (res_o.foreground),
  .res_background_level_i (res_o.background_level),
  .res_gray_level_i       (res_o.gray_level)
);

`default_nettype wire
